@@ rtl/register_file_alu_execute_unit_assert.svh @@
// Assertion macros shared by the execute unit.
`ifndef REGISTER_FILE_ALU_EXECUTE_UNIT_ASSERT_SVH
`define REGISTER_FILE_ALU_EXECUTE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define UMALU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UMALU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UMALU_ASSERT(label, clk, rst_n, prop, msg)
`define UMALU_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ rtl/umalu_pkg.sv @@
package umalu_pkg;

  localparam int unsigned RegisterCount = 8;
  localparam int unsigned RegIdxW       = (RegisterCount > 1) ? $clog2(RegisterCount) : 1;
  localparam int unsigned DataW         = 32;
  localparam int unsigned ImmW          = 25;
  localparam int unsigned IdxW          = 3;
  localparam int unsigned CmdW          = 3;
  localparam int unsigned CntW          = $clog2(DataW);

  localparam logic [CmdW-1:0] CMD_CMOV = 3'd0;
  localparam logic [CmdW-1:0] CMD_ADD  = 3'd1;
  localparam logic [CmdW-1:0] CMD_MUL  = 3'd2;
  localparam logic [CmdW-1:0] CMD_DIV  = 3'd3;
  localparam logic [CmdW-1:0] CMD_NAND = 3'd4;
  localparam logic [CmdW-1:0] CMD_LIMM = 3'd5;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [IdxW-1:0] dest_index;
    logic [IdxW-1:0] left_index;
    logic [IdxW-1:0] right_index;
    logic [ImmW-1:0] immediate;
  } cmd_t;

  typedef struct packed {
    logic             write_enable;
    logic [IdxW-1:0]  write_index;
    logic [DataW-1:0] write_value;
    logic             divide_error;
  } res_t;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

  function automatic logic [RegIdxW-1:0] reg_slot(input logic [IdxW-1:0] idx);
    return RegIdxW'(idx);
  endfunction

  function automatic logic reg_in_range(input logic [IdxW-1:0] idx);
    return 32'(idx) < RegisterCount;
  endfunction

endpackage

@@ rtl/umalu_cmd_if.sv @@
interface umalu_cmd_if;
  import umalu_pkg::*;

  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/umalu_res_if.sv @@
interface umalu_res_if;
  import umalu_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/umalu_regfile.sv @@
module umalu_regfile (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [umalu_pkg::IdxW-1:0]   rd_idx_i,
  output logic [umalu_pkg::DataW-1:0]  rd_data_o,
  input  logic                         wr_en_i,
  input  logic [umalu_pkg::IdxW-1:0]   wr_idx_i,
  input  logic [umalu_pkg::DataW-1:0]  wr_data_i
);
  import umalu_pkg::*;

  logic [DataW-1:0] regs_q [RegisterCount];

  always_comb begin
    if (reg_in_range(rd_idx_i)) begin
      rd_data_o = regs_q[reg_slot(rd_idx_i)];
    end else begin
      rd_data_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(RegisterCount); i++) begin
        regs_q[i] <= '0;
      end
    end else if (wr_en_i && reg_in_range(wr_idx_i)) begin
      regs_q[reg_slot(wr_idx_i)] <= wr_data_i;
    end
  end

endmodule

@@ rtl/umalu_alu.sv @@
module umalu_alu (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  umalu_pkg::alu_req_t          req_i,
  input  logic [umalu_pkg::DataW-1:0]  left_i,
  input  logic [umalu_pkg::DataW-1:0]  right_i,
  output umalu_pkg::alu_rsp_t          rsp_o
);
  import umalu_pkg::*;

  logic            run_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  alu_op_e         op_q;
  logic [DataW-1:0] acc_q;
  logic [DataW-1:0] opa_q;
  logic [DataW-1:0] opb_q;

  logic [DataW:0]   add_x;
  logic [DataW:0]   add_y;
  logic             add_sub;
  logic [DataW+1:0] add_sum;

  always_comb begin
    case (op_q)
      ALU_MUL: begin
        add_x   = {1'b0, acc_q};
        add_y   = {1'b0, (opb_q[0] ? opa_q : '0)};
        add_sub = 1'b0;
      end
      ALU_DIV: begin
        add_x   = {acc_q, opa_q[DataW-1]};
        add_y   = {1'b0, opb_q};
        add_sub = 1'b1;
      end
      default: begin
        add_x   = {1'b0, opa_q};
        add_y   = {1'b0, opb_q};
        add_sub = 1'b0;
      end
    endcase
    add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(DataW+1){add_sub}}} + (DataW+2)'(add_sub);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_ADD;
      acc_q  <= '0;
      opa_q  <= '0;
      opb_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      op_q   <= req_i.op;
      cnt_q  <= (req_i.op == ALU_ADD) ? '0 : CntW'(DataW - 1);
      acc_q  <= '0;
      opa_q  <= left_i;
      opb_q  <= right_i;
    end else if (run_q) begin
      case (op_q)
        ALU_MUL: begin
          acc_q <= add_sum[DataW-1:0];
          opa_q <= opa_q << 1;
          opb_q <= opb_q >> 1;
        end
        ALU_DIV: begin
          acc_q <= add_sum[DataW+1] ? add_sum[DataW-1:0] : add_x[DataW-1:0];
          opa_q <= {opa_q[DataW-2:0], add_sum[DataW+1]};
        end
        default: begin
          acc_q <= add_sum[DataW-1:0];
        end
      endcase
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == ALU_DIV) ? opa_q : acc_q;

endmodule

@@ rtl/register_file_alu_execute_unit.sv @@
// Channel   Direction  Handshake          Content
// cmd_i     in         valid/ready        one register instruction
// res_o     out        valid/ready        register write report
//
// Multiply and divide go through a read of the right operand, a launch, 32 shared adder
// steps, a step to see completion and a retire step. An add goes through the same states,
// and the other commands go from the read straight to retirement; the next transfer can
// follow in the cycle after retirement. The register file clears to zero on reset.
// A finished result waits in the output register, so a new instruction is taken
// while it stalls; retirement stalls only when that register is still full.
`include "register_file_alu_execute_unit_assert.svh"

module register_file_alu_execute_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  umalu_cmd_if.sink  cmd_i,
  umalu_res_if.source res_o
);
  import umalu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_C,
    S_START,
    S_WAIT,
    S_FINISH
  } state_e;

  state_e           state_q;
  logic [CmdW-1:0]  cmd_q;
  logic [IdxW-1:0]  dest_q;
  logic [IdxW-1:0]  right_q;
  logic [ImmW-1:0]  imm_q;
  logic [DataW-1:0] vb_q;
  logic [DataW-1:0] vc_q;
  res_t             out_q;
  logic             out_valid_q;
  logic             out_valid_d;

  logic [IdxW-1:0]  rd_idx;
  logic [DataW-1:0] rd_data;
  logic             needs_alu;
  alu_op_e          alu_op;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  res_t             res_d;
  logic             retire;
  logic             cmd_xfer;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;
  assign rd_idx      = (state_q == S_IDLE) ? cmd_i.data.left_index : right_q;

  assign needs_alu = (cmd_q == CMD_ADD) || (cmd_q == CMD_MUL) || (cmd_q == CMD_DIV);

  always_comb begin
    case (cmd_q)
      CMD_MUL: alu_op = ALU_MUL;
      CMD_DIV: alu_op = ALU_DIV;
      default: alu_op = ALU_ADD;
    endcase
  end

  assign alu_req.start = (state_q == S_START);
  assign alu_req.op    = alu_op;

  umalu_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .wr_en_i   (retire && res_d.write_enable),
    .wr_idx_i  (dest_q),
    .wr_data_i (res_d.write_value)
  );

  umalu_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (alu_req),
    .left_i  (vb_q),
    .right_i (vc_q),
    .rsp_o   (alu_rsp)
  );

  always_comb begin
    res_d              = '0;
    res_d.write_index  = dest_q;
    case (cmd_q)
      CMD_CMOV: begin
        res_d.write_enable = (vc_q != '0);
        res_d.write_value  = vb_q;
      end
      CMD_ADD, CMD_MUL: begin
        res_d.write_enable = 1'b1;
        res_d.write_value  = alu_rsp.result;
      end
      CMD_DIV: begin
        res_d.write_enable = (vc_q != '0);
        res_d.divide_error = (vc_q == '0);
        res_d.write_value  = alu_rsp.result;
      end
      CMD_NAND: begin
        res_d.write_enable = 1'b1;
        res_d.write_value  = ~(vb_q & vc_q);
      end
      CMD_LIMM: begin
        res_d.write_enable = 1'b1;
        res_d.write_value  = DataW'(imm_q);
      end
      default: begin
        res_d.write_enable = 1'b0;
      end
    endcase
    if (!reg_in_range(dest_q)) begin
      res_d.write_enable = 1'b0;
    end
    if (!res_d.write_enable) begin
      res_d.write_value = '0;
    end
  end

  assign retire      = (state_q == S_FINISH) && (!out_valid_q || res_o.ready);
  assign out_valid_d = retire || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      dest_q      <= '0;
      right_q     <= '0;
      imm_q       <= '0;
      vb_q        <= '0;
      vc_q        <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (cmd_xfer) begin
            cmd_q   <= cmd_i.data.command;
            dest_q  <= cmd_i.data.dest_index;
            right_q <= cmd_i.data.right_index;
            imm_q   <= cmd_i.data.immediate;
            vb_q    <= rd_data;
            state_q <= S_READ_C;
          end
        end
        S_READ_C: begin
          vc_q    <= rd_data;
          state_q <= needs_alu ? S_START : S_FINISH;
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (retire) begin
            out_q   <= res_d;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  `UMALU_ASSERT(a_div_error_no_write, clk_i, rst_ni, out_valid_q |-> !(out_q.divide_error && out_q.write_enable), "A divide error result also reports a write.")
  `UMALU_ASSERT(a_alu_done_in_wait, clk_i, rst_ni, alu_rsp.done |-> (state_q == S_WAIT), "The shared unit finished while the sequencer was not waiting.")
  `UMALU_ASSERT(a_full_output_holds, clk_i, rst_ni, (state_q == S_FINISH && out_valid_q && !res_o.ready) |=> (state_q == S_FINISH && $stable(out_q)), "A waiting result was overwritten.")
  `UMALU_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (state_q == S_IDLE && !out_valid_q), "The sequencer is not idle after a reset cycle.")

endmodule
